[rtl/core/client_rate_limit_admission_macros.svh]
// assertion macros for the admission block
`ifndef CLIENT_RATE_LIMIT_ADMISSION_MACROS_SVH
`define CLIENT_RATE_LIMIT_ADMISSION_MACROS_SVH

// property holds every cycle outside reset
`define CRLA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication into the next cycle
`define CRLA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/core/crla_pkg.sv]
package crla_pkg;

   localparam int CLIENT_ENTRIES    = 16;
   localparam int WHITELIST_ENTRIES = 8;
   localparam int LIST_CNT_W        = $clog2(WHITELIST_ENTRIES + 1);
   localparam int LIST_IDX_W        = (WHITELIST_ENTRIES > 1) ? $clog2(WHITELIST_ENTRIES) : 1;

   localparam logic [1:0] MODE_AUTH   = 2'd0;
   localparam logic [1:0] MODE_ADD    = 2'd1;
   localparam logic [1:0] MODE_FORGET = 2'd2;
   localparam logic [1:0] MODE_CLEAR  = 2'd3;

   localparam logic [2:0] ST_GRANTED      = 3'd0;
   localparam logic [2:0] ST_NOT_LISTED   = 3'd1;
   localparam logic [2:0] ST_RATE_LIMITED = 3'd2;
   localparam logic [2:0] ST_BAD_KEY      = 3'd3;
   localparam logic [2:0] ST_TABLE_FULL   = 3'd4;
   localparam logic [2:0] ST_LIST_FULL    = 3'd5;
   localparam logic [2:0] ST_DONE         = 3'd6;

   localparam logic [2:0] REG_AUTH_EN   = 3'd0;
   localparam logic [2:0] REG_WLIST_EN  = 3'd1;
   localparam logic [2:0] REG_MAX_REQ   = 3'd2;
   localparam logic [2:0] REG_WINDOW    = 3'd3;
   localparam logic [2:0] REG_API_KEY   = 3'd4;

   localparam logic [15:0] MAX_REQ_RESET = 16'd60;
   localparam logic [31:0] WINDOW_RESET  = 32'd60000;

   // command broadcast along the cell chain
   typedef struct packed {
      logic        write_new;
      logic        renew;
      logic        bump;
      logic        clear_one;
      logic        clear_all;
      logic [31:0] addr;
      logic [31:0] now;
   } cell_cmd_type;

   // per-cell status
   typedef struct packed {
      logic        hit;
      logic        expired;
      logic [15:0] count;
   } cell_stat_type;

endpackage

[rtl/core/client_rate_limit_admission.sv]
// channel | direction | ports
// req     | in        | req_valid, req_stall, req_mode, req_client_addr, req_provided_key, req_now_ms
// rsp     | out       | rsp_valid, rsp_stall, rsp_granted, rsp_status
// csr     | in        | csr_valid, csr_ready, csr_index, csr_data
// each word goes through accept, lookup and update across the client cell row with
// the result registered, then the result word shown; whitelist scan is a short loop.
// the result sits in an output register; the next word is taken only once it is gone.
// reset (synchronous) clears all client entries, the whitelist fill count, the CSR registers and the state.
// rsp_stall holds the result; req_stall stays high while a word is in work.
module client_rate_limit_admission (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_client_addr,
   input  logic [63:0] req_provided_key,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_granted,
   output logic [2:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_data
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_OUT  = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   logic        auth_en_ff, wlist_en_ff;
   logic [15:0] max_req_ff;
   logic [31:0] window_ff;
   logic [63:0] api_key_ff;

   logic [1:0]  mode_ff;
   logic [31:0] addr_ff, now_ff;
   logic [63:0] key_ff;

   logic [31:0] list_ff [crla_pkg::WHITELIST_ENTRIES];
   logic [crla_pkg::LIST_CNT_W-1:0] list_cnt_ff;

   logic        granted_ff;
   logic [2:0]  status_ff;

   crla_pkg::cell_cmd_type cmd;
   logic        hit, expired, has_free;
   logic [15:0] count;
   logic        listed;
   logic [15:0] count_next;
   logic [2:0]  status_c;
   logic        exec;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_granted = granted_ff;
   assign rsp_status  = status_ff;
   assign exec = (state_ff == S_EXEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         auth_en_ff  <= 1'b0;
         wlist_en_ff <= 1'b0;
         max_req_ff  <= crla_pkg::MAX_REQ_RESET;
         window_ff   <= crla_pkg::WINDOW_RESET;
         api_key_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            crla_pkg::REG_AUTH_EN:  auth_en_ff  <= csr_data[0];
            crla_pkg::REG_WLIST_EN: wlist_en_ff <= csr_data[0];
            crla_pkg::REG_MAX_REQ:  max_req_ff  <= csr_data[15:0];
            crla_pkg::REG_WINDOW:   window_ff   <= csr_data[31:0];
            crla_pkg::REG_API_KEY:  api_key_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         mode_ff <= req_mode;
         addr_ff <= req_client_addr;
         key_ff  <= req_provided_key;
         now_ff  <= req_now_ms;
      end
   end

   always_comb begin
      listed = 1'b0;
      for (int i = 0; i < crla_pkg::WHITELIST_ENTRIES; i++) begin
         if (i < int'(list_cnt_ff) && list_ff[i] == addr_ff) listed = 1'b1;
      end
   end

   assign count_next = (count == 16'hFFFF) ? count : count + 16'd1;

   always_comb begin
      status_c = crla_pkg::ST_DONE;
      case (mode_ff)
         crla_pkg::MODE_AUTH: begin
            if (wlist_en_ff && !listed) begin
               status_c = crla_pkg::ST_NOT_LISTED;
            end else if (!hit && !has_free) begin
               status_c = crla_pkg::ST_TABLE_FULL;
            end else if (hit && !expired && count_next > max_req_ff) begin
               status_c = crla_pkg::ST_RATE_LIMITED;
            end else if (auth_en_ff && key_ff != api_key_ff) begin
               status_c = crla_pkg::ST_BAD_KEY;
            end else begin
               status_c = crla_pkg::ST_GRANTED;
            end
         end
         crla_pkg::MODE_ADD: begin
            if (list_cnt_ff >= crla_pkg::LIST_CNT_W'(crla_pkg::WHITELIST_ENTRIES))
               status_c = crla_pkg::ST_LIST_FULL;
         end
         default: status_c = crla_pkg::ST_DONE;
      endcase
   end

   logic rate_go;
   assign rate_go = exec && mode_ff == crla_pkg::MODE_AUTH && !(wlist_en_ff && !listed);

   always_comb begin
      cmd.addr      = addr_ff;
      cmd.now       = now_ff;
      cmd.write_new = rate_go && !hit;
      cmd.renew     = rate_go && hit && expired;
      cmd.bump      = rate_go && hit && !expired;
      cmd.clear_one = exec && mode_ff == crla_pkg::MODE_FORGET;
      cmd.clear_all = exec && mode_ff == crla_pkg::MODE_CLEAR;
   end

   crla_table u_table (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .window_ms (window_ff),
      .hit       (hit),
      .expired   (expired),
      .count     (count),
      .has_free  (has_free)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         list_cnt_ff <= '0;
      end else if (exec && mode_ff == crla_pkg::MODE_ADD &&
                   status_c == crla_pkg::ST_DONE) begin
         list_cnt_ff <= list_cnt_ff + crla_pkg::LIST_CNT_W'(1);
      end
   end

   // written only while the count is below the depth
   always_ff @(posedge clock) begin
      if (exec && mode_ff == crla_pkg::MODE_ADD && status_c == crla_pkg::ST_DONE)
         list_ff[list_cnt_ff[crla_pkg::LIST_IDX_W-1:0]] <= addr_ff;
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         status_ff  <= status_c;
         granted_ff <= (mode_ff == crla_pkg::MODE_AUTH) && (status_c == crla_pkg::ST_GRANTED);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (req_valid) state_in = S_EXEC;
         S_EXEC: state_in = S_OUT;
         S_OUT:  if (!rsp_stall) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `include "client_rate_limit_admission_macros.svh"
   `CRLA_ASSERT(a_onehot, $onehot(state_ff), "state not one-hot")
   `CRLA_ASSERT(a_grant_status, !rsp_valid || (rsp_granted == (rsp_status == crla_pkg::ST_GRANTED)), "granted disagrees with status")
   `CRLA_ASSERT_NEXT(a_exec_out, exec, rsp_valid, "result not shown after work")
   `CRLA_ASSERT(a_list_cnt, list_cnt_ff <= crla_pkg::LIST_CNT_W'(crla_pkg::WHITELIST_ENTRIES), "whitelist count overflow")

endmodule

[rtl/core/crla_cell.sv]
module crla_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   sel,
   input  crla_pkg::cell_cmd_type cmd,
   input  logic [31:0]            window_ms,
   input  logic                   free_prev,
   output logic                   free_take,
   output logic                   free_out,
   output crla_pkg::cell_stat_type stat
);

   logic        valid_ff, valid_in;
   logic [31:0] addr_ff, start_ff;
   logic [15:0] count_ff;
   logic [31:0] elapsed;

   // lowest free cell claims the new client, chain passes "already taken" upward
   assign free_take = !valid_ff && !free_prev;
   assign free_out  = free_prev || !valid_ff;

   assign elapsed      = cmd.now - start_ff;
   assign stat.hit     = valid_ff && (addr_ff == cmd.addr);
   assign stat.expired = elapsed > window_ms;
   assign stat.count   = count_ff;

   always_comb begin
      valid_in = valid_ff;
      if (cmd.clear_all) begin
         valid_in = 1'b0;
      end else if (cmd.clear_one && sel) begin
         valid_in = 1'b0;
      end else if (cmd.write_new && free_take) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.write_new && free_take) || (cmd.renew && sel)) begin
         addr_ff  <= cmd.addr;
         start_ff <= cmd.now;
         count_ff <= 16'd1;
      end else if (cmd.bump && sel && count_ff != 16'hFFFF) begin
         count_ff <= count_ff + 16'd1;
      end
   end

endmodule

[rtl/core/crla_table.sv]
module crla_table (
   input  logic                   clock,
   input  logic                   reset,
   input  crla_pkg::cell_cmd_type cmd,
   input  logic [31:0]            window_ms,
   output logic                   hit,
   output logic                   expired,
   output logic [15:0]            count,
   output logic                   has_free
);

   crla_pkg::cell_stat_type stat [crla_pkg::CLIENT_ENTRIES];
   logic [crla_pkg::CLIENT_ENTRIES:0] free_chain;
   logic [crla_pkg::CLIENT_ENTRIES-1:0] take;
   logic [crla_pkg::CLIENT_ENTRIES-1:0] sel;

   assign free_chain[0] = 1'b0;

   // at most one cell matches since addresses are unique among valid cells
   always_comb begin
      hit     = 1'b0;
      expired = 1'b0;
      count   = '0;
      for (int i = 0; i < crla_pkg::CLIENT_ENTRIES; i++) begin
         sel[i] = stat[i].hit;
         if (stat[i].hit) begin
            hit     = 1'b1;
            expired = stat[i].expired;
            count   = stat[i].count;
         end
      end
   end

   assign has_free = free_chain[crla_pkg::CLIENT_ENTRIES];

   genvar g;
   generate
      for (g = 0; g < crla_pkg::CLIENT_ENTRIES; g++) begin : g_cell
         crla_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .sel       (sel[g]),
            .cmd       (cmd),
            .window_ms (window_ms),
            .free_prev (free_chain[g]),
            .free_take (take[g]),
            .free_out  (free_chain[g+1]),
            .stat      (stat[g])
         );
      end
   endgenerate

   `include "client_rate_limit_admission_macros.svh"
   `CRLA_ASSERT(a_one_take, $countones(take) <= 1, "more than one free cell claimed")
   `CRLA_ASSERT(a_one_hit, $countones(sel) <= 1, "client held in two cells")
   `CRLA_ASSERT(a_free_chain, has_free == (take != '0), "free chain and claim disagree")

endmodule
